[rtl/oal_pkg.sv]
// Shared constants and types for the ordered array list block.
`timescale 1ns / 1ps

package oal_pkg;

   // Field widths of the request and response words
   localparam int OP_W    = 3;
   localparam int POS_W   = 7;
   localparam int VALUE_W = 32;

   // Default list capacity
   localparam int LIST_SIZE_DEF = 64;

   // Operation codes carried in the request word
   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 3'd0,
      OP_DELETE = 3'd1,
      OP_GET    = 3'd2,
      OP_LOCATE = 3'd3,
      OP_CLEAR  = 3'd4
   } op_type;

endpackage

[rtl/oal_chan_if.sv]
// Request and response channel interfaces of the ordered array list.
`timescale 1ns / 1ps

interface oal_req_if;
   logic                               valid;
   logic                               ready;
   logic [oal_pkg::OP_W-1:0]           op;
   logic [oal_pkg::POS_W-1:0]          position;
   logic signed [oal_pkg::VALUE_W-1:0] value;

   modport source (output valid, op, position, value, input ready);
   modport sink   (input valid, op, position, value, output ready);
endinterface

interface oal_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               ok;
   logic signed [oal_pkg::VALUE_W-1:0] data_out;
   logic [oal_pkg::POS_W-1:0]          found_position;
   logic [oal_pkg::POS_W-1:0]          count_out;

   modport source (output valid, ok, data_out, found_position, count_out, input ready);
   modport sink   (input valid, ok, data_out, found_position, count_out, output ready);
endinterface

[rtl/ordered_array_list_core.sv]
// Ordered array list: positional insert, delete, get, locate and clear over a RAM.
// Usage:
//  - req_ch carries one operation word per handshake (op, position, value);
//    rsp_ch returns exactly one response word per request, in order.
//  - A request is taken only while the sequencer is idle; req_ch.ready is low
//    while an operation walks the list.
//  - Insert, delete, get and locate step through the element RAM with one read
//    per cycle, pipelined against one write per cycle. Insert visits the
//    entries at and above the position, delete the entries from the position
//    up, get one entry, locate entries until the first match. The walk runs
//    through the single RAM read port; clear, undefined and rejected requests
//    skip it. The next request is taken once the result has passed to the
//    response register.
//  - The response register parts the two sides: a new request is taken while
//    an earlier response still waits. If rsp_ch stalls, the finished result
//    holds in the sequencer until the response register frees up.
//  - Synchronous reset empties the list (count 0) and drops any pending
//    response. RAM contents are not cleared; entries beyond the count are
//    never read.
`timescale 1ns / 1ps

module ordered_array_list_core #(
   parameter int LIST_SIZE = oal_pkg::LIST_SIZE_DEF
) (
   input  logic             clock,
   input  logic             reset,
   oal_req_if.sink          req_ch,
   oal_rsp_if.source        rsp_ch
);

   localparam int AW = $clog2(LIST_SIZE);
   localparam int CW = $clog2(LIST_SIZE + 1);
   localparam int XW = ((CW > oal_pkg::POS_W) ? CW : oal_pkg::POS_W) + 1;
   localparam int VW = oal_pkg::VALUE_W;
   localparam int PW = oal_pkg::POS_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   // Control and working registers
   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [oal_pkg::OP_W-1:0] op_ff, op_in;
   logic [VW-1:0]            val_ff, val_in;
   logic [AW-1:0]            tgt_ff, tgt_in;
   logic                     ok_ff, ok_in;
   logic [VW-1:0]            data_ff, data_in;
   logic [CW-1:0]            found_ff, found_in;

   // Read walker and one-deep read pipe
   logic                     rd_go_ff, rd_go_in;
   logic [AW-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]            end_ptr_ff, end_ptr_in;
   logic                     down_ff, down_in;
   logic                     pv_ff, pv_in;
   logic [AW-1:0]            pa_ff, pa_in;

   // Response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_ok_ff, rsp_ok_in;
   logic [VW-1:0]            rsp_data_ff, rsp_data_in;
   logic [PW-1:0]            rsp_found_ff, rsp_found_in;
   logic [PW-1:0]            rsp_count_ff, rsp_count_in;

   // Element RAM
   logic [VW-1:0]            mem [LIST_SIZE];
   logic                     mem_we;
   logic [AW-1:0]            mem_waddr;
   logic [VW-1:0]            mem_wdata;
   logic [AW-1:0]            mem_raddr;
   logic [VW-1:0]            mem_rdata_ff;

   // Request checks
   logic [XW-1:0]            pos_x;
   logic [XW-1:0]            cnt_x;
   logic                     ins_ok;
   logic                     rd_ok;
   logic [AW-1:0]            pos_m1;
   logic [AW-1:0]            cnt_m1;

   assign pos_x  = XW'(req_ch.position);
   assign cnt_x  = XW'(count_ff);
   assign ins_ok = (pos_x != '0) && (pos_x <= cnt_x + XW'(1)) && (cnt_x < XW'(LIST_SIZE));
   assign rd_ok  = (pos_x != '0) && (pos_x <= cnt_x);
   assign pos_m1 = AW'(pos_x - XW'(1));
   assign cnt_m1 = AW'(cnt_x - XW'(1));

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign mem_raddr    = rd_ptr_ff;

   // Sequencer next-state logic
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      val_in       = val_ff;
      tgt_in       = tgt_ff;
      ok_in        = ok_ff;
      data_in      = data_ff;
      found_in     = found_ff;
      rd_go_in     = rd_go_ff;
      rd_ptr_in    = rd_ptr_ff;
      end_ptr_in   = end_ptr_ff;
      down_in      = down_ff;
      pv_in        = 1'b0;
      pa_in        = pa_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_found_in = rsp_found_ff;
      rsp_count_in = rsp_count_ff;
      mem_we       = 1'b0;
      mem_waddr    = tgt_ff;
      mem_wdata    = val_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               op_in    = req_ch.op;
               val_in   = req_ch.value;
               tgt_in   = pos_m1;
               ok_in    = 1'b0;
               data_in  = '0;
               found_in = '0;
               rd_go_in = 1'b0;
               state_in = ST_FINISH;
               unique case (req_ch.op)
                  oal_pkg::OP_INSERT: begin
                     if (ins_ok) begin
                        ok_in      = 1'b1;
                        state_in   = ST_WALK;
                        rd_go_in   = (pos_x != cnt_x + XW'(1));
                        rd_ptr_in  = cnt_m1;
                        end_ptr_in = pos_m1;
                        down_in    = 1'b1;
                     end
                  end
                  oal_pkg::OP_DELETE, oal_pkg::OP_GET: begin
                     if (rd_ok) begin
                        ok_in      = 1'b1;
                        state_in   = ST_WALK;
                        rd_go_in   = 1'b1;
                        rd_ptr_in  = pos_m1;
                        end_ptr_in = (req_ch.op == oal_pkg::OP_DELETE) ? cnt_m1 : pos_m1;
                        down_in    = 1'b0;
                     end
                  end
                  oal_pkg::OP_LOCATE: begin
                     state_in   = ST_WALK;
                     rd_go_in   = (count_ff != '0);
                     rd_ptr_in  = '0;
                     end_ptr_in = cnt_m1;
                     down_in    = 1'b0;
                  end
                  oal_pkg::OP_CLEAR: begin
                     ok_in    = 1'b1;
                     count_in = '0;
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end

         ST_WALK: begin
            // issue side: one read per cycle toward the end pointer
            if (rd_go_ff) begin
               pv_in = 1'b1;
               pa_in = rd_ptr_ff;
               if (rd_ptr_ff == end_ptr_ff) begin
                  rd_go_in = 1'b0;
               end else begin
                  rd_ptr_in = down_ff ? rd_ptr_ff - AW'(1) : rd_ptr_ff + AW'(1);
               end
            end
            // consume side: data of last cycle's read
            if (pv_ff) begin
               unique case (op_ff)
                  oal_pkg::OP_INSERT: begin
                     mem_we    = 1'b1;
                     mem_waddr = pa_ff + AW'(1);
                     mem_wdata = mem_rdata_ff;
                  end
                  oal_pkg::OP_DELETE: begin
                     if (pa_ff == tgt_ff) begin
                        data_in = mem_rdata_ff;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = pa_ff - AW'(1);
                        mem_wdata = mem_rdata_ff;
                     end
                  end
                  oal_pkg::OP_GET: begin
                     data_in = mem_rdata_ff;
                  end
                  oal_pkg::OP_LOCATE: begin
                     if (mem_rdata_ff == val_ff) begin
                        found_in = CW'(pa_ff) + CW'(1);
                        ok_in    = 1'b1;
                        rd_go_in = 1'b0;
                        pv_in    = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            // walk done: place the new word (insert) or shrink the count (delete), then finish
            if (!rd_go_ff && !pv_ff) begin
               state_in = ST_FINISH;
               if (op_ff == oal_pkg::OP_INSERT) begin
                  mem_we    = 1'b1;
                  mem_waddr = tgt_ff;
                  mem_wdata = val_ff;
                  count_in  = count_ff + CW'(1);
               end else if (op_ff == oal_pkg::OP_DELETE) begin
                  count_in = count_ff - CW'(1);
               end
            end
         end

         ST_FINISH: begin
            // hand the result over once the response register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_data_in  = data_ff;
               rsp_found_in = PW'(found_ff);
               rsp_count_in = PW'(count_ff);
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_go_ff     <= 1'b0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_go_ff     <= rd_go_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      val_ff       <= val_in;
      tgt_ff       <= tgt_in;
      ok_ff        <= ok_in;
      data_ff      <= data_in;
      found_ff     <= found_in;
      rd_ptr_ff    <= rd_ptr_in;
      end_ptr_ff   <= end_ptr_in;
      down_ff      <= down_in;
      pa_ff        <= pa_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_found_ff <= rsp_found_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Element RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.ok             = rsp_ok_ff;
   assign rsp_ch.data_out       = rsp_data_ff;
   assign rsp_ch.found_position = rsp_found_ff;
   assign rsp_ch.count_out      = rsp_count_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(LIST_SIZE))
      else $error("list count above capacity");

   a_walk_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_WALK |-> (!rd_go_ff && !pv_ff))
      else $error("read walker active outside walk");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0 && count_ff != $past(count_ff)) |->
      (count_ff == $past(count_ff) + CW'(1) || count_ff == $past(count_ff) - CW'(1)))
      else $error("count moved by more than one");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finish");

endmodule

[sim/ordered_array_list_core_tb.sv]
// Self-checking testbench for the ordered array list core: random and directed list operations.
`timescale 1ns / 1ps

module ordered_array_list_core_tb;

   localparam int CAP         = oal_pkg::LIST_SIZE_DEF;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_WAIT  = CAP + 16;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AT     = 60;
   localparam int RAND_ITEMS  = 400;

   // op codes the block ignores
   localparam logic [oal_pkg::OP_W-1:0] OP_RSVD5 = 3'd5;
   localparam logic [oal_pkg::OP_W-1:0] OP_RSVD6 = 3'd6;
   localparam logic [oal_pkg::OP_W-1:0] OP_RSVD7 = 3'd7;

   typedef struct {
      logic [oal_pkg::OP_W-1:0]           op;
      logic [oal_pkg::POS_W-1:0]          pos;
      logic signed [oal_pkg::VALUE_W-1:0] value;
   } list_req_type;

   typedef struct {
      logic                               ok;
      logic signed [oal_pkg::VALUE_W-1:0] data;
      logic [oal_pkg::POS_W-1:0]          found;
      logic [oal_pkg::POS_W-1:0]          count;
   } list_rsp_type;

   logic clock;
   logic reset;

   oal_req_if req_bus ();
   oal_rsp_if rsp_bus ();

   ordered_array_list_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // predicted list contents
   logic signed [oal_pkg::VALUE_W-1:0] list_mem [CAP];
   int                                 list_len;

   list_req_type req_backlog_q [$];
   list_rsp_type pending_rsp_q [$];

   int total_items;
   int accepted_cnt;
   int error_cnt = 0;
   int cycle_cnt = 0;
   int hold_left;
   bit hold_armed;
   int send_idle_pct;
   int recv_idle_pct;

   // stimulus-side length tracking, used only to pick sensible positions
   int gen_len;
   logic signed [oal_pkg::VALUE_W-1:0] value_pool [6];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Expected response of one list operation; updates the predicted list.
   function automatic list_rsp_type apply_list_op(list_req_type rq);
      list_rsp_type r;
      int p;
      r.ok    = 1'b0;
      r.data  = '0;
      r.found = '0;
      p = int'(rq.pos);
      case (rq.op)
         oal_pkg::OP_INSERT: begin
            if (p >= 1 && p <= list_len + 1 && list_len < CAP) begin
               for (int j = list_len; j >= p; j--)
                  list_mem[j] = list_mem[j-1];
               list_mem[p-1] = rq.value;
               list_len++;
               r.ok = 1'b1;
            end
         end
         oal_pkg::OP_DELETE: begin
            if (p >= 1 && p <= list_len) begin
               r.data = list_mem[p-1];
               for (int j = p; j < list_len; j++)
                  list_mem[j-1] = list_mem[j];
               list_len--;
               r.ok = 1'b1;
            end
         end
         oal_pkg::OP_GET: begin
            if (p >= 1 && p <= list_len) begin
               r.data = list_mem[p-1];
               r.ok   = 1'b1;
            end
         end
         oal_pkg::OP_LOCATE: begin
            for (int j = 0; j < list_len; j++) begin
               if (list_mem[j] == rq.value) begin
                  r.found = oal_pkg::POS_W'(j + 1);
                  r.ok    = 1'b1;
                  break;
               end
            end
         end
         oal_pkg::OP_CLEAR: begin
            list_len = 0;
            r.ok     = 1'b1;
         end
         default: ;
      endcase
      r.count = oal_pkg::POS_W'(list_len);
      return r;
   endfunction

   // Queue one word and track the list length it leaves behind.
   task automatic queue_word(input logic [oal_pkg::OP_W-1:0] op, input int pos,
                             input logic signed [oal_pkg::VALUE_W-1:0] value);
      list_req_type rq;
      rq.op    = op;
      rq.pos   = oal_pkg::POS_W'(pos);
      rq.value = value;
      req_backlog_q.push_back(rq);
      case (op)
         oal_pkg::OP_INSERT: if (pos >= 1 && pos <= gen_len + 1 && gen_len < CAP) gen_len++;
         oal_pkg::OP_DELETE: if (pos >= 1 && pos <= gen_len) gen_len--;
         oal_pkg::OP_CLEAR:  gen_len = 0;
         default: ;
      endcase
   endtask

   function automatic logic signed [oal_pkg::VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 1) == 0)
         return value_pool[$urandom_range(0, 5)];
      return $urandom;
   endfunction

   function automatic int valid_pos(input int extra);
      if (gen_len + extra < 1)
         return 1;
      return $urandom_range(1, gen_len + extra);
   endfunction

   // Stimulus, reset and end of run
   initial begin
      int r;
      int n;
      int fills;
      req_bus.valid    = 1'b0;
      req_bus.op       = '0;
      req_bus.position = '0;
      req_bus.value    = '0;
      rsp_bus.ready    = 1'b0;
      reset            = 1'b1;
      gen_len          = 0;
      fills            = 0;

      value_pool[0] = 32'sh8000_0000;
      value_pool[1] = 32'sh7fff_ffff;
      value_pool[2] = 32'sd0;
      value_pool[3] = -32'sd1;
      value_pool[4] = $urandom;
      value_pool[5] = $urandom;

      // directed: empty list, bounds, extremes, duplicates, ignored ops
      queue_word(oal_pkg::OP_CLEAR, 0, 0);
      queue_word(oal_pkg::OP_GET, 1, 0);
      queue_word(oal_pkg::OP_DELETE, 1, 0);
      queue_word(oal_pkg::OP_LOCATE, 0, 0);
      queue_word(oal_pkg::OP_INSERT, 0, 5);
      queue_word(oal_pkg::OP_INSERT, 2, 6);
      queue_word(oal_pkg::OP_INSERT, 1, 32'sh8000_0000);
      queue_word(oal_pkg::OP_INSERT, 2, 32'sh7fff_ffff);
      queue_word(oal_pkg::OP_INSERT, 1, 0);
      queue_word(oal_pkg::OP_INSERT, 2, -1);
      queue_word(oal_pkg::OP_INSERT, 127, 7);
      queue_word(oal_pkg::OP_GET, 1, 0);
      queue_word(oal_pkg::OP_GET, 4, 0);
      queue_word(oal_pkg::OP_GET, 5, 0);
      queue_word(oal_pkg::OP_GET, 0, 0);
      queue_word(oal_pkg::OP_GET, 127, 0);
      queue_word(oal_pkg::OP_INSERT, 5, -1);
      queue_word(oal_pkg::OP_LOCATE, 127, -1);
      queue_word(oal_pkg::OP_LOCATE, 0, 32'sh7fff_ffff);
      queue_word(oal_pkg::OP_LOCATE, 3, 12345);
      queue_word(oal_pkg::OP_DELETE, 6, 0);
      queue_word(oal_pkg::OP_DELETE, 0, 0);
      queue_word(oal_pkg::OP_DELETE, 2, 0);
      queue_word(oal_pkg::OP_DELETE, 4, 0);
      queue_word(OP_RSVD5, 127, $urandom);
      queue_word(OP_RSVD6, 0, $urandom);
      queue_word(OP_RSVD7, 127, 32'shffff_ffff);
      queue_word(oal_pkg::OP_CLEAR, 127, 0);

      // random: mostly in-range operations, some noise, two runs to a full list
      n = 0;
      while (n < RAND_ITEMS) begin
         if ((fills == 0 && n >= 120) || (fills == 1 && n >= 280)) begin
            fills++;
            while (gen_len < CAP) begin
               queue_word(oal_pkg::OP_INSERT, valid_pos(1), pick_value());
               n++;
            end
            queue_word(oal_pkg::OP_INSERT, CAP + 1, pick_value());
            queue_word(oal_pkg::OP_INSERT, 1, pick_value());
            queue_word(oal_pkg::OP_GET, CAP, 0);
            queue_word(oal_pkg::OP_GET, CAP + 1, 0);
            queue_word(oal_pkg::OP_LOCATE, 0, pick_value());
            queue_word(oal_pkg::OP_DELETE, CAP, 0);
            queue_word(oal_pkg::OP_DELETE, 1, 0);
            n += 7;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 38)
               queue_word(oal_pkg::OP_INSERT, valid_pos(1), pick_value());
            else if (r < 56)
               queue_word(oal_pkg::OP_DELETE, valid_pos(0), $urandom);
            else if (r < 70)
               queue_word(oal_pkg::OP_GET, valid_pos(0), $urandom);
            else if (r < 84)
               queue_word(oal_pkg::OP_LOCATE, $urandom_range(0, 127), pick_value());
            else if (r < 87)
               queue_word(oal_pkg::OP_CLEAR, $urandom_range(0, 127), $urandom);
            else
               queue_word(oal_pkg::OP_W'($urandom_range(0, 7)), $urandom_range(0, 127),
                          $urandom);
            n++;
         end
      end
      total_items = req_backlog_q.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (accepted_cnt < total_items || pending_rsp_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_cnt == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // idle rates by phase of the run
   always_comb begin
      if (accepted_cnt < total_items / 3) begin
         send_idle_pct = 9;
         recv_idle_pct = 66;
      end else if (accepted_cnt < (2 * total_items) / 3) begin
         send_idle_pct = 66;
         recv_idle_pct = 9;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   end

   // Driver: predict on each accepted word, then offer the next one
   always @(posedge clock) begin
      list_req_type rq;
      if (reset) begin
         req_bus.valid <= 1'b0;
         list_len      = 0;
         accepted_cnt  <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            rq.op    = req_bus.op;
            rq.pos   = req_bus.position;
            rq.value = req_bus.value;
            pending_rsp_q.push_back(apply_list_op(rq));
            accepted_cnt <= accepted_cnt + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_backlog_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               rq = req_backlog_q.pop_front();
               req_bus.valid    <= 1'b1;
               req_bus.op       <= rq.op;
               req_bus.position <= rq.pos;
               req_bus.value    <= rq.value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off so the block backs up and stalls its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         hold_armed <= 1'b1;
      end else if (hold_armed && accepted_cnt >= HOLD_AT) begin
         hold_left  <= HOLD_CYCLES;
         hold_armed <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Receiver ready
   always @(posedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Monitor: compare each response word with the oldest prediction
   always @(posedge clock) begin
      list_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp_q.size() == 0) begin
            if (error_cnt < 10)
               $display("unexpected word: ok=%0b data=%0d found=%0d count=%0d",
                        rsp_bus.ok, rsp_bus.data_out, rsp_bus.found_position,
                        rsp_bus.count_out);
            error_cnt++;
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_bus.ok !== want.ok || rsp_bus.data_out !== want.data ||
                rsp_bus.found_position !== want.found || rsp_bus.count_out !== want.count) begin
               if (error_cnt < 10) begin
                  $display("mismatch: exp ok=%0b data=%0d found=%0d count=%0d",
                           want.ok, want.data, want.found, want.count);
                  $display("          got ok=%0b data=%0d found=%0d count=%0d",
                           rsp_bus.ok, rsp_bus.data_out, rsp_bus.found_position,
                           rsp_bus.count_out);
               end
               error_cnt++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule
